[hw/rtl/tlpw_pkg.sv]
// Shared types, constants and the sequencer microcode for the page table walker.
// Used by every module of the walker except tlpw_ram; depends on nothing else.
`default_nettype none

package tlpw_pkg;

  localparam int unsigned CfgW    = 12;
  localparam int unsigned LdAddrW = 12;
  localparam int unsigned VaW     = 14;
  localparam int unsigned PaW     = 12;
  localparam int unsigned StepW   = 4;
  localparam int unsigned WideW   = 17;

  localparam logic MODE_LOAD      = 1'b0;
  localparam logic MODE_TRANSLATE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [LdAddrW-1:0] load_address;
    logic [7:0]         load_byte;
    logic [VaW-1:0]     virtual_address;
  } in_item_t;

  typedef struct packed {
    logic           outer_valid;
    logic           inner_valid;
    logic [PaW-1:0] physical_address;
    logic [31:0]    physical_value;
  } out_item_t;

  typedef enum logic [2:0] {
    ASEL_NEXT,
    ASEL_OUTER,
    ASEL_INNER,
    ASEL_PHYS,
    ASEL_LOAD
  } asel_e;

  typedef enum logic [2:0] {
    JC_NONE,
    JC_IDLE,
    JC_FAULT,
    JC_EMIT,
    JC_ALWAYS
  } jcond_e;

  typedef struct packed {
    logic             acc;
    logic             rd;
    logic             wr;
    logic             shift;
    asel_e            asel;
    logic             set_ov;
    logic             set_iv;
    logic             emit;
    jcond_e           jc;
    logic [StepW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic mode;
    logic fault;
    logic out_free;
  } status_t;

  localparam logic [StepW-1:0] StepIdle  = 4'd0;
  localparam logic [StepW-1:0] StepOut0  = 4'd1;
  localparam logic [StepW-1:0] StepOut1  = 4'd2;
  localparam logic [StepW-1:0] StepOut2  = 4'd3;
  localparam logic [StepW-1:0] StepOut3  = 4'd4;
  localparam logic [StepW-1:0] StepInn0  = 4'd5;
  localparam logic [StepW-1:0] StepInn1  = 4'd6;
  localparam logic [StepW-1:0] StepInn2  = 4'd7;
  localparam logic [StepW-1:0] StepInn3  = 4'd8;
  localparam logic [StepW-1:0] StepPhys0 = 4'd9;
  localparam logic [StepW-1:0] StepPhys1 = 4'd10;
  localparam logic [StepW-1:0] StepPhys2 = 4'd11;
  localparam logic [StepW-1:0] StepPhys3 = 4'd12;
  localparam logic [StepW-1:0] StepEmit  = 4'd13;
  localparam logic [StepW-1:0] StepWrite = 4'd14;

  function automatic ctrl_t ucode_word(logic [StepW-1:0] step);
    ctrl_t cw;
    cw        = '0;
    cw.asel   = ASEL_NEXT;
    cw.jc     = JC_NONE;
    cw.target = StepIdle;
    unique case (step)
      StepIdle: begin
        cw.acc    = 1'b1;
        cw.jc     = JC_IDLE;
        cw.target = StepWrite;
      end
      StepOut0: begin
        cw.rd   = 1'b1;
        cw.asel = ASEL_OUTER;
      end
      StepOut1, StepOut2, StepOut3, StepInn1, StepInn2, StepInn3,
      StepPhys1, StepPhys2, StepPhys3: begin
        cw.rd    = 1'b1;
        cw.shift = 1'b1;
      end
      StepInn0: begin
        cw.rd     = 1'b1;
        cw.shift  = 1'b1;
        cw.asel   = ASEL_INNER;
        cw.set_ov = 1'b1;
        cw.jc     = JC_FAULT;
        cw.target = StepEmit;
      end
      StepPhys0: begin
        cw.rd     = 1'b1;
        cw.shift  = 1'b1;
        cw.asel   = ASEL_PHYS;
        cw.set_iv = 1'b1;
        cw.jc     = JC_FAULT;
        cw.target = StepEmit;
      end
      StepEmit: begin
        cw.emit   = 1'b1;
        cw.jc     = JC_EMIT;
        cw.target = StepIdle;
      end
      StepWrite: begin
        cw.wr     = 1'b1;
        cw.asel   = ASEL_LOAD;
        cw.jc     = JC_ALWAYS;
        cw.target = StepIdle;
      end
      default: begin
        cw.jc     = JC_ALWAYS;
        cw.target = StepIdle;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tlpw_ram.sv]
// Generic single-port RAM with one write or read per cycle and registered read data.
// Stands alone; no package needed.
`default_nettype none

module tlpw_ram #(
  parameter int unsigned DATA_WIDTH = 8,
  parameter int unsigned DEPTH      = 4096,
  parameter int unsigned ADDR_WIDTH = $clog2(DEPTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic                  re_i,
  input  wire logic [ADDR_WIDTH-1:0] addr_i,
  input  wire logic [DATA_WIDTH-1:0] wdata_i,
  output logic      [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/tlpw_seq.sv]
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on tlpw_pkg for the control word, status and microcode.
`default_nettype none

module tlpw_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire tlpw_pkg::status_t status_i,
  output tlpw_pkg::ctrl_t        ctrl_o
);

  logic [tlpw_pkg::StepW-1:0] pc_q;
  logic [tlpw_pkg::StepW-1:0] pc_d;
  logic [tlpw_pkg::StepW-1:0] pc_inc;
  tlpw_pkg::ctrl_t            cw;

  assign cw     = tlpw_pkg::ucode_word(pc_q);
  assign pc_inc = pc_q + tlpw_pkg::StepW'(1);
  assign ctrl_o = cw;

  always_comb begin
    pc_d = pc_inc;
    unique case (cw.jc)
      tlpw_pkg::JC_NONE: pc_d = pc_inc;
      tlpw_pkg::JC_IDLE: begin
        if (!in_valid_i) begin
          pc_d = pc_q;
        end else if (status_i.mode == tlpw_pkg::MODE_TRANSLATE) begin
          pc_d = pc_inc;
        end else begin
          pc_d = cw.target;
        end
      end
      tlpw_pkg::JC_FAULT:  pc_d = status_i.fault ? cw.target : pc_inc;
      tlpw_pkg::JC_EMIT:   pc_d = status_i.out_free ? cw.target : pc_q;
      tlpw_pkg::JC_ALWAYS: pc_d = cw.target;
      default:             pc_d = tlpw_pkg::StepIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= tlpw_pkg::StepIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tlpw_dp.sv]
// Walker datapath: base register, address unit, word assembly, flags and result register.
// Depends on tlpw_pkg and instantiates tlpw_ram for the physical memory.
`default_nettype none

module tlpw_dp #(
  parameter int unsigned PHYS_ADDR_BITS = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tlpw_pkg::ctrl_t               ctrl_i,
  input  wire logic                          in_valid_i,
  input  wire tlpw_pkg::in_item_t            in_data_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic [tlpw_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output tlpw_pkg::out_item_t                out_data_o,
  output tlpw_pkg::status_t                  status_o
);

  localparam int unsigned MemDepth = 1 << PHYS_ADDR_BITS;

  logic [tlpw_pkg::CfgW-1:0]   base_q;
  tlpw_pkg::in_item_t          in_q;
  logic [PHYS_ADDR_BITS-1:0]   addr_q;
  logic [PHYS_ADDR_BITS-1:0]   mem_addr;
  logic [23:0]                 word_q;
  logic                        ov_q;
  logic                        iv_q;
  logic [tlpw_pkg::PaW-1:0]    pa_q;
  logic                        out_valid_q;
  tlpw_pkg::out_item_t         out_q;
  logic [7:0]                  rdata;
  logic [tlpw_pkg::WideW-1:0]  outer_sum;
  logic [tlpw_pkg::WideW-1:0]  inner_sum;
  logic [tlpw_pkg::WideW-1:0]  phys_wide;
  logic [tlpw_pkg::WideW-1:0]  load_wide;
  logic [tlpw_pkg::WideW-1:0]  pa_wide;
  logic                        out_free;
  logic                        accept;

  assign accept    = ctrl_i.acc && in_valid_i;
  assign out_free  = !out_valid_q || out_ready_i;

  assign outer_sum = tlpw_pkg::WideW'(base_q)
                   + tlpw_pkg::WideW'({in_q.virtual_address[13:10], 2'b00});
  assign inner_sum = tlpw_pkg::WideW'(word_q[23:12])
                   + tlpw_pkg::WideW'({in_q.virtual_address[9:6], 2'b00});
  assign phys_wide = tlpw_pkg::WideW'({word_q[23:18], in_q.virtual_address[5:0]});
  assign load_wide = tlpw_pkg::WideW'(in_q.load_address);
  assign pa_wide   = tlpw_pkg::WideW'(phys_wide[PHYS_ADDR_BITS-1:0]);

  always_comb begin
    mem_addr = addr_q;
    case (ctrl_i.asel)
      tlpw_pkg::ASEL_NEXT:  mem_addr = addr_q;
      tlpw_pkg::ASEL_OUTER: mem_addr = outer_sum[PHYS_ADDR_BITS-1:0];
      tlpw_pkg::ASEL_INNER: mem_addr = inner_sum[PHYS_ADDR_BITS-1:0];
      tlpw_pkg::ASEL_PHYS:  mem_addr = phys_wide[PHYS_ADDR_BITS-1:0];
      tlpw_pkg::ASEL_LOAD:  mem_addr = load_wide[PHYS_ADDR_BITS-1:0];
      default:              mem_addr = addr_q;
    endcase
  end

  tlpw_ram #(
    .DATA_WIDTH (8),
    .DEPTH      (MemDepth)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr),
    .re_i    (ctrl_i.rd),
    .addr_i  (mem_addr),
    .wdata_i (in_q.load_byte),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (ctrl_i.rd) begin
      addr_q <= mem_addr + {{(PHYS_ADDR_BITS-1){1'b0}}, 1'b1};
    end
    if (ctrl_i.shift) begin
      word_q <= {word_q[15:0], rdata};
    end
    if (ctrl_i.set_iv) begin
      pa_q <= pa_wide[tlpw_pkg::PaW-1:0];
    end
    if (ctrl_i.emit && out_free) begin
      out_q.outer_valid      <= ov_q;
      out_q.inner_valid      <= iv_q;
      out_q.physical_address <= iv_q ? pa_q : '0;
      out_q.physical_value   <= iv_q ? {word_q, rdata} : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      ov_q        <= 1'b0;
      iv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        base_q <= cfg_data_i;
      end
      if (accept) begin
        ov_q <= 1'b0;
        iv_q <= 1'b0;
      end else begin
        if (ctrl_i.set_ov) begin
          ov_q <= rdata[0];
        end
        if (ctrl_i.set_iv) begin
          iv_q <= rdata[0];
        end
      end
      if (ctrl_i.emit && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign status_o.mode     = in_data_i.mode;
  assign status_o.fault    = !rdata[0];
  assign status_o.out_free = out_free;

endmodule

`default_nettype wire

[hw/rtl/two_level_page_walker.sv]
// A translate transaction makes twelve byte reads from the single-port byte memory plus
// the accept and emit steps. An outer fault skips to the emit step after the outer entry,
// an inner fault after the inner entry, and a load goes from the accept step to a write step.
// The result register lets the next transaction be accepted while a result waits.
// Reset clears the step counter, the base register, the walk flags and the result valid;
// memory contents are undefined until loaded.
`default_nettype none

module two_level_page_walker #(
  parameter int unsigned PHYS_ADDR_BITS = 12
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire tlpw_pkg::in_item_t        in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output tlpw_pkg::out_item_t            out_data_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [tlpw_pkg::CfgW-1:0] cfg_data_i
);

  tlpw_pkg::ctrl_t   ctrl;
  tlpw_pkg::status_t status;

  tlpw_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  tlpw_dp #(
    .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .status_o    (status)
  );

  assign in_ready_o  = ctrl.acc;
  assign cfg_ready_o = 1'b1;

endmodule

`default_nettype wire

[hw/rtl/tlpw_checker.sv]
// Port-level checker for the page table walker, bound to the top level.
// Depends on tlpw_pkg and on the port names of two_level_page_walker.
`default_nettype none

module tlpw_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire tlpw_pkg::in_item_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire tlpw_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Result transaction dropped or changed while stalled.");

  a_inner_needs_outer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.inner_valid |-> out_data_o.outer_valid)
    else $error("Inner entry reported valid after an outer fault.");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.inner_valid |->
      out_data_o.physical_address == '0 && out_data_o.physical_value == '0)
    else $error("Faulting translation returned a nonzero address or value.");

  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.mode == tlpw_pkg::MODE_TRANSLATE
      |=> !in_ready_o)
    else $error("New transaction accepted while a walk is in progress.");

endmodule

bind two_level_page_walker tlpw_checker u_checker (.*);

`default_nettype wire
